### rtl/core/bpdc_pkg.sv
package bpdc_pkg;

  // Width of the hold, repeat and lockout counters.
  localparam int COUNT_WIDTH = 16;
  // Width of the threshold registers.
  localparam int THR_WIDTH = 16;
  // Compare width that holds both a counter and a threshold.
  localparam int CMP_WIDTH = (COUNT_WIDTH > THR_WIDTH) ? COUNT_WIDTH : THR_WIDTH;

  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH = THR_WIDTH;

  localparam int IN_TDATA_WIDTH = 8;
  localparam int OUT_TDATA_WIDTH = 8;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [THR_WIDTH-1:0] thr_t;
  typedef logic [CMP_WIDTH-1:0] cmp_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_REPEAT_MODE  = 3'd0,
    CFG_SHORT_TICKS  = 3'd1,
    CFG_MEDIUM_TICKS = 3'd2,
    CFG_LONG_TICKS   = 3'd3,
    CFG_REPEAT_TICKS = 3'd4,
    CFG_AUTO_CLEAR   = 3'd5
  } cfg_index_t;

  typedef enum logic [1:0] {
    PH_OPEN    = 2'd0,
    PH_PRESSED = 2'd1,
    PH_BLOCKED = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_SHORT  = 3'd1,
    EV_MEDIUM = 3'd2,
    EV_LONG   = 3'd3,
    EV_REPEAT = 3'd4
  } event_t;

  typedef struct packed {
    logic repeat_mode;
    thr_t short_ticks;
    thr_t medium_ticks;
    thr_t long_ticks;
    thr_t repeat_ticks;
    logic auto_clear;
  } cfg_t;

  typedef struct packed {
    logic   release_new;
    logic   press_new;
    event_t release_result;
    event_t press_result;
  } result_t;

  function automatic count_t sat_inc(input count_t v);
    return (v == '1) ? v : count_t'(v + count_t'(1));
  endfunction

endpackage

### rtl/core/bpdc_cfg_regs.sv
module bpdc_cfg_regs
  import bpdc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [CFG_INDEX_WIDTH-1:0] wr_index,
  input  logic [CFG_DATA_WIDTH-1:0]  wr_data,
  output cfg_t                       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        CFG_REPEAT_MODE:  cfg_nxt.repeat_mode  = wr_data[0];
        CFG_SHORT_TICKS:  cfg_nxt.short_ticks  = thr_t'(wr_data);
        CFG_MEDIUM_TICKS: cfg_nxt.medium_ticks = thr_t'(wr_data);
        CFG_LONG_TICKS:   cfg_nxt.long_ticks   = thr_t'(wr_data);
        CFG_REPEAT_TICKS: cfg_nxt.repeat_ticks = thr_t'(wr_data);
        CFG_AUTO_CLEAR:   cfg_nxt.auto_clear   = wr_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.repeat_mode  <= 1'b0;
      cfg_r.short_ticks  <= thr_t'(5);
      cfg_r.medium_ticks <= thr_t'(100);
      cfg_r.long_ticks   <= thr_t'(300);
      cfg_r.repeat_ticks <= thr_t'(20);
      cfg_r.auto_clear   <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/core/bpdc_engine.sv
module bpdc_engine
  import bpdc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    step,
  input  logic    req_type,
  input  logic    contact_open,
  output result_t result
);

  phase_t phase_r, phase_nxt;
  count_t hold_r, hold_nxt;
  count_t rep_r, rep_nxt;
  count_t lock_r, lock_nxt;
  event_t press_r, press_nxt;
  event_t rel_r, rel_nxt;

  cmp_t   hold_c;
  cmp_t   rep_c;
  cmp_t   lock_inc_c;
  cmp_t   short_c;
  cmp_t   medium_c;
  cmp_t   long_c;
  cmp_t   thr_c;
  event_t band;
  count_t lock_inc;

  assign hold_c     = cmp_t'(hold_r);
  assign rep_c      = cmp_t'(rep_r);
  assign short_c    = cmp_t'(cfg.short_ticks);
  assign medium_c   = cmp_t'(cfg.medium_ticks);
  assign long_c     = cmp_t'(cfg.long_ticks);
  assign lock_inc   = sat_inc(lock_r);
  assign lock_inc_c = cmp_t'(lock_inc);

  // Bands are tested in order; a count that falls in none raises nothing.
  always_comb begin
    priority if (hold_c >= short_c && hold_c < medium_c) begin
      band  = EV_SHORT;
      thr_c = short_c;
    end else if (hold_c >= medium_c && hold_c < long_c) begin
      band  = EV_MEDIUM;
      thr_c = medium_c;
    end else if (hold_c >= long_c) begin
      band  = EV_LONG;
      thr_c = long_c;
    end else begin
      band  = EV_NONE;
      thr_c = '0;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    hold_nxt  = hold_r;
    rep_nxt   = rep_r;
    lock_nxt  = lock_r;
    press_nxt = press_r;
    rel_nxt   = rel_r;
    result    = '0;

    if (req_type) begin
      // A block request leaves the counters and the stores alone.
      phase_nxt = PH_BLOCKED;
    end else begin
      if (cfg.auto_clear) begin
        press_nxt = EV_NONE;
        rel_nxt   = EV_NONE;
      end
      unique case (phase_r)
        PH_OPEN: begin
          if (!contact_open) begin
            phase_nxt = PH_PRESSED;
            hold_nxt  = '0;
            rep_nxt   = '0;
          end
        end
        PH_BLOCKED: begin
          lock_nxt = lock_inc;
          if (contact_open && lock_inc_c >= short_c) begin
            lock_nxt  = '0;
            phase_nxt = PH_OPEN;
          end
        end
        default: begin
          // The unused phase code behaves as pressed.
          hold_nxt = sat_inc(hold_r);
          rep_nxt  = sat_inc(rep_r);
          if (band != EV_NONE) begin
            priority if (contact_open) begin
              rel_nxt            = band;
              result.release_new = 1'b1;
              phase_nxt          = PH_OPEN;
            end else if (hold_c == thr_c) begin
              if (band != EV_SHORT) begin
                rep_nxt = sat_inc('0);
              end
              press_nxt        = band;
              result.press_new = 1'b1;
            end else if (band != EV_SHORT && cfg.repeat_mode &&
                         rep_c == cmp_t'(cfg.repeat_ticks)) begin
              rep_nxt          = sat_inc('0);
              press_nxt        = EV_REPEAT;
              result.press_new = 1'b1;
            end
          end
        end
      endcase
    end

    result.press_result   = press_nxt;
    result.release_result = rel_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_OPEN;
      hold_r  <= '0;
      rep_r   <= '0;
      lock_r  <= '0;
      press_r <= EV_NONE;
      rel_r   <= EV_NONE;
    end else if (step) begin
      phase_r <= phase_nxt;
      hold_r  <= hold_nxt;
      rep_r   <= rep_nxt;
      lock_r  <= lock_nxt;
      press_r <= press_nxt;
      rel_r   <= rel_nxt;
    end
  end

endmodule

### rtl/core/bpdc_out_stage.sv
module bpdc_out_stage
  import bpdc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t load_data,
  output logic    can_load,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    valid_r, valid_nxt;
  result_t data_r;

  // The register may take a new result in the same cycle that the old one
  // leaves.
  assign can_load = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

### rtl/core/button_press_duration_classifier.sv
// Button press classifier: every transfer on the input stream is one tick
// (contact sample) or one block request, and each one yields exactly one
// result transfer holding the press and release stores and the two event
// flags. One item is taken per clock cycle; the only stage is the output
// register, which accepts a new result in the same cycle that the waiting
// one is taken, so the rate is limited only by the downstream ready. The user
// must write thresholds via the configuration channel only while the stream
// is idle, not enforced by the block. Counters saturate at their maximum.
module button_press_duration_classifier
  import bpdc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // [0] contact_open, [7:1] zero
  input  logic [IN_TDATA_WIDTH-1:0]  in_tdata,
  // [0] req_type
  input  logic                       in_tuser,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // [2:0] press_result, [5:3] release_result, [6] press_new, [7] release_new
  output logic [OUT_TDATA_WIDTH-1:0] out_tdata,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

  cfg_t    cfg;
  result_t step_result;
  result_t out_result;
  logic    can_load;
  logic    in_xfer;

  assign cfg_ready = rst_n;
  assign in_tready = rst_n && can_load;
  assign in_xfer   = in_tvalid && in_tready;

  bpdc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  bpdc_engine u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .step         (in_xfer),
    .req_type     (in_tuser),
    .contact_open (in_tdata[0]),
    .result       (step_result)
  );

  bpdc_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_xfer),
    .load_data (step_result),
    .can_load  (can_load),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_result)
  );

  assign out_tdata = OUT_TDATA_WIDTH'(out_result);

endmodule

### rtl/core/bpdc_checker.sv
module bpdc_checker
  import bpdc_pkg::*;
(
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [OUT_TDATA_WIDTH-1:0] out_tdata
);

  // A raised press event always leaves a band or repeat code in the store.
  a_press_new_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[6]) |->
      (out_tdata[2:0] != EV_NONE && out_tdata[2:0] <= EV_REPEAT))
    else $error("press event without a valid press code");

  // A raised release event names a band, never repeat.
  a_release_new_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[7]) |->
      (out_tdata[5:3] != EV_NONE && out_tdata[5:3] <= EV_LONG))
    else $error("release event without a valid band code");

  // Every accepted item shows up as a result in the next cycle.
  a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> out_tvalid)
    else $error("accepted item produced no result");

  // A result that is not taken stays unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed or vanished");

endmodule

bind button_press_duration_classifier bpdc_checker u_bpdc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### test/button_press_duration_classifier_tb.sv
`timescale 1ns / 100ps

module button_press_duration_classifier_tb;
  import bpdc_pkg::*;

  localparam int RECEIVER_HOLD_CYCLES = 300;
  localparam int MAX_REPORTS = 20;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  // [0] contact_open, [7:1] zero
  logic [IN_TDATA_WIDTH-1:0] in_tdata = '0;
  // [0] req_type
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  // [2:0] press_result, [5:3] release_result, [6] press_new, [7] release_new
  logic [OUT_TDATA_WIDTH-1:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;

  button_press_duration_classifier dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Classifier state mirrored by the testbench, plus the register settings.
  cfg_t settings = '{repeat_mode: 1'b0, short_ticks: 16'd5, medium_ticks: 16'd100,
                     long_ticks: 16'd300, repeat_ticks: 16'd20, auto_clear: 1'b0};
  phase_t cur_phase = PH_OPEN;
  count_t hold_cnt = '0;
  count_t rep_cnt = '0;
  count_t lock_cnt = '0;
  event_t press_st = EV_NONE;
  event_t release_st = EV_NONE;

  result_t expected_results[$];

  bit src_idle = 1'b1;
  bit sink_idle = 1'b1;
  bit hold_request = 1'b0;

  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned cfg_writes = 0;
  int unsigned press_events = 0;
  int unsigned release_events = 0;
  int unsigned mismatch_count = 0;

  function automatic count_t bump_sat(count_t v);
    return (v == {COUNT_WIDTH{1'b1}}) ? v : count_t'(v + 1'b1);
  endfunction

  // Advance the mirrored classifier by one accepted item and queue the result.
  task automatic classify_item(bit block_req, bit contact_open);
    event_t band;
    thr_t thr;
    bit pnew;
    bit rnew;
    pnew = 1'b0;
    rnew = 1'b0;
    if (block_req) begin
      cur_phase = PH_BLOCKED;
    end else begin
      if (settings.auto_clear) begin
        press_st = EV_NONE;
        release_st = EV_NONE;
      end
      case (cur_phase)
        PH_OPEN: begin
          if (!contact_open) begin
            cur_phase = PH_PRESSED;
            hold_cnt = '0;
            rep_cnt = '0;
          end
        end
        PH_BLOCKED: begin
          lock_cnt = bump_sat(lock_cnt);
          if (contact_open && lock_cnt >= settings.short_ticks) begin
            lock_cnt = '0;
            cur_phase = PH_OPEN;
          end
        end
        default: begin
          band = EV_NONE;
          thr = '0;
          if (hold_cnt >= settings.short_ticks && hold_cnt < settings.medium_ticks) begin
            band = EV_SHORT;
            thr = settings.short_ticks;
          end else if (hold_cnt >= settings.medium_ticks && hold_cnt < settings.long_ticks) begin
            band = EV_MEDIUM;
            thr = settings.medium_ticks;
          end else if (hold_cnt >= settings.long_ticks) begin
            band = EV_LONG;
            thr = settings.long_ticks;
          end
          if (band != EV_NONE) begin
            if (contact_open) begin
              release_st = band;
              rnew = 1'b1;
              cur_phase = PH_OPEN;
            end else if (hold_cnt == thr) begin
              if (band != EV_SHORT) rep_cnt = '0;
              press_st = band;
              pnew = 1'b1;
            end else if (band != EV_SHORT && settings.repeat_mode &&
                         rep_cnt == settings.repeat_ticks) begin
              rep_cnt = '0;
              press_st = EV_REPEAT;
              pnew = 1'b1;
            end
          end
          hold_cnt = bump_sat(hold_cnt);
          rep_cnt = bump_sat(rep_cnt);
        end
      endcase
    end
    press_events += pnew;
    release_events += rnew;
    expected_results.push_back('{release_new: rnew, press_new: pnew,
                                 release_result: release_st, press_result: press_st});
  endtask

  task automatic report_mismatch(string msg);
    if (mismatch_count < MAX_REPORTS) $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // Leaves in_tvalid high across back-to-back items, with random gaps while src_idle is set.
  task automatic send_tick(bit block_req, bit contact_open);
    if (src_idle && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= block_req;
    in_tdata <= IN_TDATA_WIDTH'(contact_open);
    do @(posedge clk); while (!in_tready);
    items_sent++;
    classify_item(block_req, contact_open);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic put_setting(cfg_index_t idx, thr_t value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_writes++;
    case (idx)
      CFG_REPEAT_MODE:  settings.repeat_mode = value[0];
      CFG_SHORT_TICKS:  settings.short_ticks = value;
      CFG_MEDIUM_TICKS: settings.medium_ticks = value;
      CFG_LONG_TICKS:   settings.long_ticks = value;
      CFG_REPEAT_TICKS: settings.repeat_ticks = value;
      CFG_AUTO_CLEAR:   settings.auto_clear = value[0];
      default: ;
    endcase
  endtask

  // Only called while nothing is in flight.
  task automatic program_settings(cfg_t s);
    put_setting(CFG_REPEAT_MODE, thr_t'(s.repeat_mode));
    put_setting(CFG_SHORT_TICKS, s.short_ticks);
    put_setting(CFG_MEDIUM_TICKS, s.medium_ticks);
    put_setting(CFG_LONG_TICKS, s.long_ticks);
    put_setting(CFG_REPEAT_TICKS, s.repeat_ticks);
    put_setting(CFG_AUTO_CLEAR, thr_t'(s.auto_clear));
    cfg_valid <= 1'b0;
  endtask

  function automatic thr_t pick_threshold(int unsigned hi);
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return '1;
      2:       return thr_t'($urandom_range(0, 65535));
      default: return thr_t'($urandom_range(0, hi));
    endcase
  endfunction

  function automatic cfg_t random_settings();
    cfg_t s;
    s.repeat_mode = 1'($urandom_range(0, 1));
    s.short_ticks = pick_threshold(6);
    s.medium_ticks = pick_threshold(20);
    s.long_ticks = pick_threshold(40);
    s.repeat_ticks = pick_threshold(5);
    s.auto_clear = 1'($urandom_range(0, 1));
    return s;
  endfunction

  task automatic test_basic_walk();
    program_settings('{repeat_mode: 1'b1, short_ticks: 16'd2, medium_ticks: 16'd4,
                       long_ticks: 16'd6, repeat_ticks: 16'd1, auto_clear: 1'b0});
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    // An early release is not acted on until the short threshold is reached.
    repeat (3) send_tick(1'b0, 1'b1);
    // Short, medium, repeat and long, then a long release.
    repeat (8) send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    drain_results();
  endtask

  task automatic test_lockout();
    program_settings('{repeat_mode: 1'b0, short_ticks: 16'd2, medium_ticks: 16'd4,
                       long_ticks: 16'd6, repeat_ticks: 16'd1, auto_clear: 1'b1});
    repeat (3) send_tick(1'b0, 1'b0);
    // The contact sample of a block request is ignored and the stores survive.
    send_tick(1'b1, 1'b1);
    repeat (2) send_tick(1'b0, 1'b0);
    repeat (2) send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    drain_results();
  endtask

  task automatic test_threshold_extremes();
    program_settings('{repeat_mode: 1'b1, short_ticks: 16'd0, medium_ticks: 16'd0,
                       long_ticks: 16'd0, repeat_ticks: 16'd0, auto_clear: 1'b0});
    repeat (2) send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    drain_results();
    program_settings('{repeat_mode: 1'b1, short_ticks: 16'hFFFF, medium_ticks: 16'hFFFF,
                       long_ticks: 16'hFFFF, repeat_ticks: 16'hFFFF, auto_clear: 1'b1});
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    drain_results();
    // Medium below short leaves a gap below the medium threshold.
    program_settings('{repeat_mode: 1'b0, short_ticks: 16'd5, medium_ticks: 16'd3,
                       long_ticks: 16'd4, repeat_ticks: 16'd2, auto_clear: 1'b0});
    repeat (5) send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    drain_results();
  endtask

  task automatic test_receiver_hold();
    program_settings(random_settings());
    hold_request = 1'b1;
    repeat (40) send_tick($urandom_range(0, 5) == 0, 1'($urandom_range(0, 1)));
    drain_results();
  endtask

  task automatic test_random_sessions(int unsigned target);
    int unsigned stop_at;
    int unsigned next_cfg;
    int unsigned n;
    int unsigned choice;
    stop_at = items_sent + target;
    next_cfg = items_sent;
    while (items_sent < stop_at) begin
      if (items_sent >= next_cfg) begin
        drain_results();
        program_settings(random_settings());
        next_cfg = items_sent + $urandom_range(60, 200);
      end
      choice = $urandom_range(0, 9);
      if (choice <= 6) begin
        repeat ($urandom_range(0, 3)) send_tick(1'b0, 1'b1);
        repeat ($urandom_range(0, 50)) send_tick(1'b0, 1'b0);
        n = 0;
        while (cur_phase == PH_PRESSED && n < 60) begin
          send_tick(1'b0, 1'b1);
          n++;
        end
      end else if (choice == 7) begin
        send_tick(1'b1, 1'($urandom_range(0, 1)));
        repeat ($urandom_range(0, 6)) send_tick(1'b0, 1'b0);
        n = 0;
        while (cur_phase == PH_BLOCKED && n < 60) begin
          send_tick(1'b0, 1'b1);
          n++;
        end
      end else begin
        repeat ($urandom_range(1, 10))
          send_tick($urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)));
      end
    end
    drain_results();
  endtask

  // Receiver side: random stalls, or one long hold-off when requested.
  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (RECEIVER_HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
        out_tready <= 1'b1;
      end else if (sink_idle && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = result_t'(out_tdata);
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result transfer 0x%02h with nothing expected", out_tdata));
      end else begin
        want = expected_results.pop_front();
        results_seen++;
        if (got.press_result !== want.press_result)
          report_mismatch($sformatf("result %0d press_result %0d, expected %0d",
                                    results_seen, got.press_result, want.press_result));
        if (got.release_result !== want.release_result)
          report_mismatch($sformatf("result %0d release_result %0d, expected %0d",
                                    results_seen, got.release_result, want.release_result));
        if (got.press_new !== want.press_new)
          report_mismatch($sformatf("result %0d press_new %b, expected %b",
                                    results_seen, got.press_new, want.press_new));
        if (got.release_new !== want.release_new)
          report_mismatch($sformatf("result %0d release_new %b, expected %b",
                                    results_seen, got.release_new, want.release_new));
      end
    end
  end

  initial begin
    #4_000_000;
    $display("Timeout with %0d results still expected.", expected_results.size());
    $display("button_press_duration_classifier verification failed");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_walk();
    test_lockout();
    test_threshold_extremes();
    test_receiver_hold();
    test_random_sessions(1500);
    // The closing part of the run turns off the random source gaps and sink stalls.
    src_idle = 1'b0;
    sink_idle = 1'b0;
    test_random_sessions(500);
    repeat (4) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    $display("Sent %0d items and checked %0d results across %0d register writes.",
             items_sent, results_seen, cfg_writes);
    $display("Saw %0d press and %0d release events, with extreme thresholds and stalls.",
             press_events, release_events);
    if (mismatch_count == 0) begin
      $display("button_press_duration_classifier verification clean");
    end else begin
      $display("button_press_duration_classifier verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/bpdc_pkg.sv
rtl/core/bpdc_cfg_regs.sv
rtl/core/bpdc_engine.sv
rtl/core/bpdc_out_stage.sv
rtl/core/button_press_duration_classifier.sv
rtl/core/bpdc_checker.sv
test/button_press_duration_classifier_tb.sv
